FILE: src/i2cms_pkg.sv
package i2cms_pkg;

    localparam int WRITE_DEPTH_DEF = 16;
    localparam int READ_LIMIT_DEF  = 32;

    typedef logic [1:0] t_req;
    typedef logic [2:0] t_action;
    typedef logic [2:0] t_result;

    localparam t_req REQ_LOAD  = 2'd0;
    localparam t_req REQ_START = 2'd1;
    localparam t_req REQ_EVENT = 2'd2;

    localparam t_action ACT_NONE     = 3'd0;
    localparam t_action ACT_ADDR     = 3'd1;
    localparam t_action ACT_DATA     = 3'd2;
    localparam t_action ACT_STOP     = 3'd3;
    localparam t_action ACT_RECV     = 3'd4;
    localparam t_action ACT_NACKSTOP = 3'd5;

    localparam t_result RES_NONE     = 3'd0;
    localparam t_result RES_OK       = 3'd1;
    localparam t_result RES_OVERFLOW = 3'd2;
    localparam t_result RES_ARBLOST  = 3'd3;
    localparam t_result RES_BUSERR   = 3'd4;
    localparam t_result RES_NACK     = 3'd5;
    localparam t_result RES_FAIL     = 3'd6;
    localparam t_result RES_REJECTED = 3'd7;

endpackage

FILE: src/i2c_master_transaction_sequencer.sv
// I2C master write-then-read transaction sequencer.
// Input channel (i_valid / o_ready) takes one request per transfer: a load
// of a byte into the write store, a start of a transaction, or a bus
// interrupt event with its flags and received byte.
// Output channel (o_valid / i_ready) returns exactly one result per request:
// the next bus action and value, a received byte with its index, and a
// done flag with the result code once the transaction ends.
// The decision is made from the request and the current transaction state
// and lands in the result register at the edge that accepts the request.
// Throughput is one request per cycle while the receiver does not stall; the
// single result register is the only stage.
// While the receiver stalls, the result holds and a new request is taken
// only in the cycle in which the held result leaves.
// Reset clears the transaction state to idle and empties the result
// register. Write store entries are undefined until loaded.
module i2c_master_transaction_sequencer #(
    parameter int WRITE_DEPTH = i2cms_pkg::WRITE_DEPTH_DEF,
    parameter int READ_LIMIT  = i2cms_pkg::READ_LIMIT_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  i2cms_pkg::t_req      i_req_type,
    input  logic [6:0]           i_slave_addr,
    input  logic [4:0]           i_write_count,
    input  logic [7:0]           i_read_count,
    input  logic [3:0]           i_buf_index,
    input  logic [7:0]           i_buf_byte,
    input  logic                 i_flag_arblost,
    input  logic                 i_flag_buserr,
    input  logic                 i_flag_wif,
    input  logic                 i_flag_rif,
    input  logic                 i_flag_rxack,
    input  logic [7:0]           i_bus_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output i2cms_pkg::t_action   o_bus_action,
    output logic [7:0]           o_bus_value,
    output logic                 o_rx_valid,
    output logic [7:0]           o_rx_byte,
    output logic [7:0]           o_rx_index,
    output logic                 o_done_res,
    output i2cms_pkg::t_result   o_result_code,
    output logic                 o_busy_res
);
    import i2cms_pkg::*;

    // Only the first sixteen positions can ever be loaded.
    localparam int STORE_DEPTH = (WRITE_DEPTH < 16) ? WRITE_DEPTH : 16;
    localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic [7:0] r_store [STORE_DEPTH];

    logic       r_busy, n_busy;
    logic [6:0] r_addr, n_addr;
    logic [4:0] r_write_total, n_write_total;
    logic [7:0] r_read_total, n_read_total;
    logic [4:0] r_write_done, n_write_done;
    logic [7:0] r_read_done, n_read_done;

    logic       r_valid;
    t_action    r_action, n_action;
    logic [7:0] r_value, n_value;
    logic       r_rx_valid, n_rx_valid;
    logic [7:0] r_rx_byte, n_rx_byte;
    logic [7:0] r_rx_index, n_rx_index;
    logic       r_done, n_done;
    t_result    r_code, n_code;

    logic       accept;
    logic       store_we;
    logic [4:0] wc_sat;
    logic [8:0] read_next;
    logic [7:0] store_rd;

    assign o_ready  = !r_valid || i_ready;
    assign accept   = i_valid && o_ready;
    assign store_we = accept && (i_req_type == REQ_LOAD)
                      && (32'(i_buf_index) < 32'(STORE_DEPTH));
    assign wc_sat   = (32'(i_write_count) > 32'(WRITE_DEPTH)) ? 5'(WRITE_DEPTH)
                                                              : i_write_count;
    assign read_next = {1'b0, r_read_done} + 9'd1;
    assign store_rd  = r_store[r_write_done[STORE_AW-1:0]];

    always_comb begin
        n_busy        = r_busy;
        n_addr        = r_addr;
        n_write_total = r_write_total;
        n_read_total  = r_read_total;
        n_write_done  = r_write_done;
        n_read_done   = r_read_done;
        n_action      = ACT_NONE;
        n_value       = 8'd0;
        n_rx_valid    = 1'b0;
        n_rx_byte     = 8'd0;
        n_rx_index    = 8'd0;
        n_done        = 1'b0;
        n_code        = RES_NONE;
        case (i_req_type)
            REQ_START: begin
                if (r_busy) begin
                    n_code = RES_REJECTED;
                end else begin
                    n_busy        = 1'b1;
                    n_addr        = i_slave_addr;
                    n_write_total = wc_sat;
                    n_read_total  = i_read_count;
                    n_write_done  = 5'd0;
                    n_read_done   = 8'd0;
                    if (wc_sat != 5'd0) begin
                        n_action = ACT_ADDR;
                        n_value  = {i_slave_addr, 1'b0};
                    end else if (i_read_count != 8'd0) begin
                        n_action = ACT_ADDR;
                        n_value  = {i_slave_addr, 1'b1};
                    end else begin
                        n_busy = 1'b0;
                        n_done = 1'b1;
                        n_code = RES_OK;
                    end
                end
            end
            REQ_EVENT: begin
                if (r_busy) begin
                    if (i_flag_arblost || i_flag_buserr) begin
                        n_busy = 1'b0;
                        n_done = 1'b1;
                        n_code = i_flag_buserr ? RES_BUSERR : RES_ARBLOST;
                    end else if (i_flag_wif) begin
                        if (i_flag_rxack) begin
                            n_action = ACT_STOP;
                            n_busy   = 1'b0;
                            n_done   = 1'b1;
                            n_code   = RES_NACK;
                        end else if (r_write_done < r_write_total) begin
                            n_action     = ACT_DATA;
                            n_value      = store_rd;
                            n_write_done = r_write_done + 5'd1;
                        end else if (r_read_done < r_read_total) begin
                            // Repeated start with the read direction bit.
                            n_action = ACT_ADDR;
                            n_value  = {r_addr, 1'b1};
                        end else begin
                            n_action = ACT_STOP;
                            n_busy   = 1'b0;
                            n_done   = 1'b1;
                            n_code   = RES_OK;
                        end
                    end else if (i_flag_rif) begin
                        if (32'(r_read_done) < 32'(READ_LIMIT)) begin
                            n_rx_valid  = 1'b1;
                            n_rx_byte   = i_bus_data;
                            n_rx_index  = r_read_done;
                            n_read_done = read_next[7:0];
                            if (read_next < {1'b0, r_read_total}) begin
                                n_action = ACT_RECV;
                            end else begin
                                n_action = ACT_NACKSTOP;
                                n_busy   = 1'b0;
                                n_done   = 1'b1;
                                n_code   = RES_OK;
                            end
                        end else begin
                            n_action = ACT_STOP;
                            n_busy   = 1'b0;
                            n_done   = 1'b1;
                            n_code   = RES_OVERFLOW;
                        end
                    end else begin
                        n_busy = 1'b0;
                        n_done = 1'b1;
                        n_code = RES_FAIL;
                    end
                end
            end
            default: begin
                // Loads and unknown requests leave the transaction alone.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[i_buf_index[STORE_AW-1:0]] <= i_buf_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= 1'b0;
            r_busy        <= 1'b0;
            r_addr        <= 7'd0;
            r_write_total <= 5'd0;
            r_read_total  <= 8'd0;
            r_write_done  <= 5'd0;
            r_read_done   <= 8'd0;
        end else begin
            if (accept) begin
                r_valid       <= 1'b1;
                r_busy        <= n_busy;
                r_addr        <= n_addr;
                r_write_total <= n_write_total;
                r_read_total  <= n_read_total;
                r_write_done  <= n_write_done;
                r_read_done   <= n_read_done;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action   <= n_action;
            r_value    <= n_value;
            r_rx_valid <= n_rx_valid;
            r_rx_byte  <= n_rx_byte;
            r_rx_index <= n_rx_index;
            r_done     <= n_done;
            r_code     <= n_code;
        end
    end

    assign o_valid       = r_valid;
    assign o_bus_action  = r_action;
    assign o_bus_value   = r_value;
    assign o_rx_valid    = r_rx_valid;
    assign o_rx_byte     = r_rx_byte;
    assign o_rx_index    = r_rx_index;
    assign o_done_res    = r_done;
    assign o_result_code = r_code;
    assign o_busy_res    = r_busy;

endmodule

FILE: src/i2cms_checker.sv
module i2cms_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_valid,
    input logic                 i_ready,
    input i2cms_pkg::t_action   o_bus_action,
    input logic                 o_rx_valid,
    input logic                 o_done_res,
    input i2cms_pkg::t_result   o_result_code,
    input logic                 o_busy_res
);
    import i2cms_pkg::*;

    // A held result must not change while the receiver stalls.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_bus_action)
                                && $stable(o_result_code))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // A received byte always comes with a request for the next byte or the stop.
    a_rx_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rx_valid |->
            o_bus_action == ACT_RECV || o_bus_action == ACT_NACKSTOP)
        else $error("received byte without a read action");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res |-> !o_busy_res && o_result_code != RES_NONE)
        else $error("finished transaction still busy or without code");

    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result_code == RES_REJECTED |-> o_busy_res && !o_done_res)
        else $error("rejected start while idle");

endmodule

bind i2c_master_transaction_sequencer i2cms_checker u_i2cms_checker (.*);
